FILE: hw/rtl/rmte_pkg.sv
// types, constants and helper functions shared by the rotation matrix to euler angle pipeline
`default_nettype none

package rmte_pkg;

    // fixed point formats
    localparam int ELEMENT_FRAC_BITS = 14;
    localparam int ANGLE_FRAC_BITS   = 13;
    localparam int ELEM_W            = 16;
    localparam int ANG_Q             = 30;
    localparam int ANG_SHIFT         = ANG_Q - ANGLE_FRAC_BITS;

    // square root: radicand up to one squared, one result bit per step
    localparam int SQRT_STEPS = ELEMENT_FRAC_BITS + 1;
    localparam int SQ_D_W     = 2 * ELEMENT_FRAC_BITS + 1;
    localparam int SQ_R_W     = SQ_D_W + 1;

    // cordic datapath
    localparam int CORDIC_STEPS = 28;
    localparam int NORM_BIT     = 40;
    localparam int CW           = NORM_BIT + 4;
    localparam int ZW           = 35;
    localparam int OPW          = ELEM_W + 2;

    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W   = 16;
    localparam int OUT_W   = 48;
    localparam int IN_W    = 9 * ELEM_W;

    // lane numbering
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;
    localparam int LANES      = 3;

    typedef enum logic [1:0] {
        BASE_NONE,
        BASE_POS_PI,
        BASE_NEG_PI
    } base_t;

    typedef struct packed {
        logic  zero;
        base_t base;
    } lane_ctl_t;

    typedef struct packed {
        logic      lock;
        logic      pos;
        lane_ctl_t [LANES-1:0] lane;
    } ctl_t;

    typedef struct packed {
        logic                    lock;
        logic                    pos;
        logic signed [OPW-1:0]   roll_y;
        logic signed [OPW-1:0]   roll_x;
        logic signed [OPW-1:0]   pitch_y;
        logic signed [OPW-1:0]   yaw_y;
        logic signed [OPW-1:0]   yaw_x;
    } side_t;

    // atan(2^-i) in q30
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd8;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // position of the highest set bit
    function automatic logic [3:0] msb_pos(input logic [15:0] v);
        logic [3:0] p;
        p = '0;
        for (int b = 0; b < 16; b++) begin
            if (v[b]) begin
                p = 4'(b);
            end
        end
        return p;
    endfunction

    // symmetric rounding from q30 to the output format, saturated to w bits
    function automatic logic [15:0] round_sat(input logic signed [ZW-1:0] a, input int w);
        logic [ZW-1:0]        mag;
        logic [ZW-1:0]        q;
        logic signed [ZW:0]   r;
        logic signed [ZW:0]   hi;
        logic signed [ZW:0]   lo;
        mag = a[ZW-1] ? ZW'(-a) : ZW'(a);
        q   = (mag + (ZW'(1) << (ANG_SHIFT - 1))) >> ANG_SHIFT;
        r   = a[ZW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        hi  = (ZW+1)'((64'sd1 <<< (w - 1)) - 64'sd1);
        lo  = -hi - (ZW+1)'(1);
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rotation_matrix_to_euler_angles.sv
// rotation matrix to negated zyx euler angles, pipelined sqrt and cordic
`default_nettype none

// channel   dir  tdata                                   tuser
// s_axis    in   m00..m22, 9 x 16 bit q1.14               -
// m_axis    out  roll 16, pitch 15, yaw 16 (q2.13), pad   gimbal_lock
//
// one word per cycle while the output register is free or taken
// 15 square root steps and 28 unrolled cordic steps per lane
// the whole pipeline advances when the output register is free or taken
// a stall freezes every stage, so nothing is lost or repeated
// aresetn clears only the valid bits of every stage

module rotation_matrix_to_euler_angles
    import rmte_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, zero pad from bit 0 up
    output logic [OUT_W-1:0]       m_axis_tdata,
    // gimbal_lock
    output logic                   m_axis_tuser
);

    // global advance
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // input stage: lock detect and operand selection
    // ------------------------------------------------------------------
    logic signed [ELEM_W-1:0] m00, m01, m10, m11, m20, m21, m22;
    assign m00 = s_axis_tdata[0*ELEM_W +: ELEM_W];
    assign m01 = s_axis_tdata[1*ELEM_W +: ELEM_W];
    assign m10 = s_axis_tdata[3*ELEM_W +: ELEM_W];
    assign m11 = s_axis_tdata[4*ELEM_W +: ELEM_W];
    assign m20 = s_axis_tdata[6*ELEM_W +: ELEM_W];
    assign m21 = s_axis_tdata[7*ELEM_W +: ELEM_W];
    assign m22 = s_axis_tdata[8*ELEM_W +: ELEM_W];

    localparam logic signed [ELEM_W-1:0] ONE_P = ELEM_W'(1 << ELEMENT_FRAC_BITS);
    localparam logic signed [ELEM_W-1:0] ONE_N = -ONE_P;

    logic                            in_vld_reg;
    side_t                           in_side_reg, in_side_next;
    logic [ELEMENT_FRAC_BITS-1:0]    in_v_reg, in_v_next;

    always_comb begin
        in_side_next.lock    = (m20 >= ONE_P) || (m20 <= ONE_N);
        in_side_next.pos     = (m20 > 0);
        in_side_next.roll_y  = OPW'(m21);
        in_side_next.roll_x  = OPW'(m22);
        in_side_next.pitch_y = OPW'(m20);
        // under lock the yaw comes from the second column instead of the first
        in_side_next.yaw_y   = in_side_next.lock ? -OPW'(m01) : OPW'(m10);
        in_side_next.yaw_x   = in_side_next.lock ? OPW'(m11) : OPW'(m00);
        // magnitude of m20, only needed below one
        if (in_side_next.lock) begin
            in_v_next = '0;
        end else if (m20[ELEM_W-1]) begin
            in_v_next = ELEMENT_FRAC_BITS'(-m20);
        end else begin
            in_v_next = ELEMENT_FRAC_BITS'(m20);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_side_reg <= in_side_next;
            in_v_reg    <= in_v_next;
        end
    end

    // ------------------------------------------------------------------
    // square stage and restoring square root, one result bit per stage
    // ------------------------------------------------------------------
    logic                sv_reg    [0:SQRT_STEPS];
    side_t               sside_reg [0:SQRT_STEPS];
    logic [SQ_D_W-1:0]   sd_reg    [0:SQRT_STEPS];
    logic [SQ_R_W-1:0]   sr_reg    [0:SQRT_STEPS];
    logic [SQ_D_W-1:0]   sd_next   [0:SQRT_STEPS];
    logic [SQ_R_W-1:0]   sr_next   [0:SQRT_STEPS];

    // radicand is one squared minus m20 squared
    assign sd_next[0] = (SQ_D_W'(1) << (2 * ELEMENT_FRAC_BITS))
                        - SQ_D_W'(in_v_reg * in_v_reg);
    assign sr_next[0] = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            sv_reg[0] <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sside_reg[0] <= in_side_reg;
            sd_reg[0]    <= sd_next[0];
            sr_reg[0]    <= sr_next[0];
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_R_W:0] BIT = (SQ_R_W+1)'(1) << (2 * (ELEMENT_FRAC_BITS - k));
        logic [SQ_R_W:0] trial;

        assign trial = {1'b0, sr_reg[k]} + BIT;

        always_comb begin
            if ({{(SQ_R_W+1-SQ_D_W){1'b0}}, sd_reg[k]} >= trial) begin
                sd_next[k+1] = sd_reg[k] - trial[SQ_D_W-1:0];
                sr_next[k+1] = (sr_reg[k] >> 1) + BIT[SQ_R_W-1:0];
            end else begin
                sd_next[k+1] = sd_reg[k];
                sr_next[k+1] = sr_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k+1] <= 1'b0;
            end else if (en) begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sside_reg[k+1] <= sside_reg[k];
                sd_reg[k+1]    <= sd_next[k+1];
                sr_reg[k+1]    <= sr_next[k+1];
            end
        end
    end

    // ------------------------------------------------------------------
    // normalise stage: quadrant fold and left shift so the larger
    // magnitude reaches bit NORM_BIT
    // ------------------------------------------------------------------
    logic signed [OPW-1:0] ny [0:LANES-1];
    logic signed [OPW-1:0] nx [0:LANES-1];

    assign ny[LANE_ROLL]  = sside_reg[SQRT_STEPS].roll_y;
    assign nx[LANE_ROLL]  = sside_reg[SQRT_STEPS].roll_x;
    assign ny[LANE_PITCH] = sside_reg[SQRT_STEPS].pitch_y;
    assign nx[LANE_PITCH] = $signed({{(OPW-ELEMENT_FRAC_BITS-1){1'b0}},
                                     sr_reg[SQRT_STEPS][ELEMENT_FRAC_BITS:0]});
    assign ny[LANE_YAW]   = sside_reg[SQRT_STEPS].yaw_y;
    assign nx[LANE_YAW]   = sside_reg[SQRT_STEPS].yaw_x;

    logic                  cv_reg  [0:CORDIC_STEPS];
    ctl_t                  ctl_reg [0:CORDIC_STEPS];
    ctl_t                  ctl_next;
    logic signed [CW-1:0]  cx_reg  [0:LANES-1][0:CORDIC_STEPS];
    logic signed [CW-1:0]  cy_reg  [0:LANES-1][0:CORDIC_STEPS];
    logic signed [CW-1:0]  cx_next [0:LANES-1];
    logic signed [CW-1:0]  cy_next [0:LANES-1];

    always_comb begin
        logic signed [OPW-1:0] ax;
        logic signed [OPW-1:0] ay;
        logic [15:0]           mx;
        logic [15:0]           my;
        logic [15:0]           mm;
        logic [5:0]            sh;
        ctl_next.lock = sside_reg[SQRT_STEPS].lock;
        ctl_next.pos  = sside_reg[SQRT_STEPS].pos;
        for (int l = 0; l < LANES; l++) begin
            ax = nx[l];
            ay = ny[l];
            ctl_next.lane[l].base = BASE_NONE;
            if (nx[l][OPW-1]) begin
                ctl_next.lane[l].base = ny[l][OPW-1] ? BASE_NEG_PI : BASE_POS_PI;
                ax = -nx[l];
                ay = -ny[l];
            end
            ctl_next.lane[l].zero = (nx[l] == '0) && (ny[l] == '0);
            mx = ax[15:0];
            my = ay[OPW-1] ? 16'(-ay) : ay[15:0];
            mm = (mx > my) ? mx : my;
            sh = 6'(NORM_BIT) - {2'b00, msb_pos(mm)};
            if (ctl_next.lane[l].zero) begin
                cx_next[l] = '0;
                cy_next[l] = '0;
            end else begin
                cx_next[l] = $signed({{(CW-OPW){ax[OPW-1]}}, ax}) <<< sh;
                cy_next[l] = $signed({{(CW-OPW){ay[OPW-1]}}, ay}) <<< sh;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            cv_reg[0] <= sv_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[0] <= ctl_next;
            for (int l = 0; l < LANES; l++) begin
                cx_reg[l][0] <= cx_next[l];
                cy_reg[l][0] <= cy_next[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // vectoring cordic, one micro-rotation per stage on all three lanes
    // ------------------------------------------------------------------
    logic signed [ZW-1:0] cz_reg [0:LANES-1][1:CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = $signed({3'b000, atan_q30(i)});
        logic signed [CW-1:0] x_next [0:LANES-1];
        logic signed [CW-1:0] y_next [0:LANES-1];
        logic signed [ZW-1:0] z_next [0:LANES-1];
        logic signed [ZW-1:0] z_in   [0:LANES-1];

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            if (i == 0) begin : g_first
                assign z_in[l] = '0;
            end else begin : g_rest
                assign z_in[l] = cz_reg[l][i];
            end

            always_comb begin
                logic signed [CW-1:0] dx;
                logic signed [CW-1:0] dy;
                dx = cy_reg[l][i] >>> i;
                dy = cx_reg[l][i] >>> i;
                if (!cy_reg[l][i][CW-1] && (cy_reg[l][i] != '0)) begin
                    x_next[l] = cx_reg[l][i] + dx;
                    y_next[l] = cy_reg[l][i] - dy;
                    z_next[l] = z_in[l] + ATAN;
                end else begin
                    x_next[l] = cx_reg[l][i] - dx;
                    y_next[l] = cy_reg[l][i] + dy;
                    z_next[l] = z_in[l] - ATAN;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    cx_reg[l][i+1] <= x_next[l];
                    cy_reg[l][i+1] <= y_next[l];
                    cz_reg[l][i+1] <= z_next[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (en) begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctl_reg[i+1] <= ctl_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // angle stage: quadrant base, sign and the lock overrides
    // ------------------------------------------------------------------
    logic                  ang_vld_reg;
    logic                  ang_lock_reg;
    logic signed [ZW-1:0]  ang_reg  [0:LANES-1];
    logic signed [ZW-1:0]  ang_next [0:LANES-1];

    always_comb begin
        logic signed [ZW-1:0] sum [0:LANES-1];
        ctl_t                 c;
        c = ctl_reg[CORDIC_STEPS];
        for (int l = 0; l < LANES; l++) begin
            case (c.lane[l].base)
                BASE_POS_PI: sum[l] = cz_reg[l][CORDIC_STEPS] + PI_Q30;
                BASE_NEG_PI: sum[l] = cz_reg[l][CORDIC_STEPS] - PI_Q30;
                default:     sum[l] = cz_reg[l][CORDIC_STEPS];
            endcase
            if (c.lane[l].zero) begin
                sum[l] = '0;
            end
        end
        // roll is fixed at zero under lock
        ang_next[LANE_ROLL] = c.lock ? '0 : -sum[LANE_ROLL];
        ang_next[LANE_YAW]  = -sum[LANE_YAW];
        if (c.lock) begin
            ang_next[LANE_PITCH] = c.pos ? HALF_PI_Q30 : -HALF_PI_Q30;
        end else begin
            ang_next[LANE_PITCH] = sum[LANE_PITCH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_vld_reg <= 1'b0;
        end else if (en) begin
            ang_vld_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_lock_reg <= ctl_reg[CORDIC_STEPS].lock;
            for (int l = 0; l < LANES; l++) begin
                ang_reg[l] <= ang_next[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: rounding to q2.13 with saturation
    // ------------------------------------------------------------------
    logic [15:0]         roll_r, pitch_r, yaw_r;
    logic [OUT_W-1:0]    m_tdata_next;

    assign roll_r  = round_sat(ang_reg[LANE_ROLL], ROLL_W);
    assign pitch_r = round_sat(ang_reg[LANE_PITCH], PITCH_W);
    assign yaw_r   = round_sat(ang_reg[LANE_YAW], YAW_W);
    assign m_tdata_next = {{(OUT_W-ROLL_W-PITCH_W-YAW_W){1'b0}},
                           yaw_r[YAW_W-1:0], pitch_r[PITCH_W-1:0], roll_r[ROLL_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= ang_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_axis_tdata <= m_tdata_next;
            m_axis_tuser <= ang_lock_reg;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    logic signed [PITCH_W-1:0] pitch_out;
    assign pitch_out = $signed(m_axis_tdata[ROLL_W +: PITCH_W]);

    a_lock_roll_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[ROLL_W-1:0] == '0)
        else $error("roll not zero under gimbal lock");

    a_lock_pitch_quarter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            pitch_out == 15'sd12868 || pitch_out == -15'sd12868)
        else $error("pitch not a quarter turn under gimbal lock");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> pitch_out >= -15'sd12868 && pitch_out <= 15'sd12868)
        else $error("pitch beyond a quarter turn");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |=> $stable(ang_vld_reg) && $stable(cv_reg[CORDIC_STEPS])
                           && $stable(sv_reg[SQRT_STEPS]))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
